// ----- hdl/scfp_pkg.sv -----
`default_nettype none

package scfp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned SUM_W  = 16;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 3;

    localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'd58;
    localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'd13;

    // Register index, taken from paddr bit 2 (registers sit at 4-byte spacing).
    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        logic [BYTE_W-1:0] slave_id;
        logic [BYTE_W-1:0] command_code;
        logic [BYTE_W-1:0] payload_length;
        logic              checksum_good;
    } t_result;

endpackage

`default_nettype wire

// ----- hdl/scfp_core.sv -----
`default_nettype none

module scfp_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic [scfp_pkg::BYTE_W-1:0] i_byte,
    input  wire logic [scfp_pkg::BYTE_W-1:0] i_start_marker,
    input  wire logic [scfp_pkg::BYTE_W-1:0] i_end_marker,
    output logic                            o_res_valid,
    output scfp_pkg::t_result               o_res
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SLAVE,
        PH_CMD,
        PH_LEN,
        PH_PAYLOAD,
        PH_SUM_HI,
        PH_SUM_LO,
        PH_TRAIL
    } t_phase;

    t_phase                        r_phase, n_phase;
    logic [scfp_pkg::BYTE_W-1:0]   r_slave, n_slave;
    logic [scfp_pkg::BYTE_W-1:0]   r_command, n_command;
    logic [scfp_pkg::BYTE_W-1:0]   r_length, n_length;
    logic [scfp_pkg::BYTE_W-1:0]   r_count, n_count;
    logic [scfp_pkg::SUM_W-1:0]    r_sum, n_sum;
    logic [scfp_pkg::SUM_W-1:0]    r_rx_sum, n_rx_sum;
    logic [scfp_pkg::SUM_W-1:0]    byte_ext;
    logic [scfp_pkg::SUM_W-1:0]    total;
    logic [scfp_pkg::BYTE_W-1:0]   count_inc;

    assign byte_ext  = {{(scfp_pkg::SUM_W-scfp_pkg::BYTE_W){1'b0}}, i_byte};
    assign total     = r_sum + {{(scfp_pkg::SUM_W-scfp_pkg::BYTE_W){1'b0}}, i_end_marker};
    assign count_inc = r_count + 8'd1;

    always_comb begin
        n_phase   = r_phase;
        n_slave   = r_slave;
        n_command = r_command;
        n_length  = r_length;
        n_count   = r_count;
        n_sum     = r_sum;
        n_rx_sum  = r_rx_sum;

        o_res_valid          = 1'b0;
        o_res.kind           = scfp_pkg::KIND_PAYLOAD;
        o_res.payload_byte   = '0;
        o_res.payload_index  = '0;
        o_res.slave_id       = r_slave;
        o_res.command_code   = r_command;
        o_res.payload_length = r_length;
        o_res.checksum_good  = 1'b0;

        case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_start_marker) begin
                    n_sum    = byte_ext;
                    n_count  = '0;
                    n_rx_sum = '0;
                    n_phase  = PH_SLAVE;
                end
            end
            PH_SLAVE: begin
                n_slave = i_byte;
                n_sum   = r_sum + byte_ext;
                n_phase = PH_CMD;
            end
            PH_CMD: begin
                n_command = i_byte;
                n_sum     = r_sum + byte_ext;
                n_phase   = PH_LEN;
            end
            PH_LEN: begin
                n_length = i_byte;
                n_sum    = r_sum + byte_ext;
                n_count  = '0;
                n_phase  = (i_byte == '0) ? PH_SUM_HI : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_sum               = r_sum + byte_ext;
                o_res_valid         = 1'b1;
                o_res.payload_byte  = i_byte;
                o_res.payload_index = r_count;
                n_count             = count_inc;
                if (count_inc == r_length) begin
                    n_phase = PH_SUM_HI;
                end
            end
            PH_SUM_HI: begin
                n_rx_sum = {i_byte, {scfp_pkg::BYTE_W{1'b0}}};
                n_phase  = PH_SUM_LO;
            end
            PH_SUM_LO: begin
                n_rx_sum = {r_rx_sum[scfp_pkg::SUM_W-1:scfp_pkg::BYTE_W], i_byte};
                n_phase  = PH_TRAIL;
            end
            PH_TRAIL: begin
                // The trailing byte itself is not checked; only its arrival matters.
                o_res_valid         = 1'b1;
                o_res.kind          = scfp_pkg::KIND_STATUS;
                o_res.checksum_good = (total == r_rx_sum);
                n_phase             = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_slave   <= '0;
            r_command <= '0;
            r_length  <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_rx_sum  <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_slave   <= n_slave;
            r_command <= n_command;
            r_length  <= n_length;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_rx_sum  <= n_rx_sum;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sum_checked_frame_parser.sv -----
// Channel   Direction  Handshake                 Payload
// rx        in         i_rx_valid / o_rx_stall   i_rx_byte
// result    out        o_res_valid / i_res_stall o_kind .. o_checksum_good
// config    in         psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// One received byte is taken every cycle while o_rx_stall is low; a byte's
// result is registered at the edge that takes it, in the output register or,
// if that is full, in the one-entry skid register, which lets the next byte in
// while a result waits; o_rx_stall rises only once both hold a result. Reset is
// synchronous and active low; it puts the parser in hunt, markers at 58 and 13.
`default_nettype none

module sum_checked_frame_parser (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,

    input  wire logic                        i_rx_valid,
    output logic                             o_rx_stall,
    input  wire logic [scfp_pkg::BYTE_W-1:0] i_rx_byte,

    output logic                             o_res_valid,
    input  wire logic                        i_res_stall,
    output logic                             o_kind,
    output logic [scfp_pkg::BYTE_W-1:0]      o_payload_byte,
    output logic [scfp_pkg::BYTE_W-1:0]      o_payload_index,
    output logic [scfp_pkg::BYTE_W-1:0]      o_slave_id,
    output logic [scfp_pkg::BYTE_W-1:0]      o_command_code,
    output logic [scfp_pkg::BYTE_W-1:0]      o_payload_length,
    output logic                             o_checksum_good,

    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [scfp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [scfp_pkg::DATA_W-1:0] pwdata,
    output logic [scfp_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);

    logic [scfp_pkg::BYTE_W-1:0] r_start_marker;
    logic [scfp_pkg::BYTE_W-1:0] r_end_marker;
    logic                        cfg_write;
    logic                        reg_sel;

    logic                        rx_accept;
    logic                        core_valid;
    scfp_pkg::t_result           core_res;
    logic                        produce;
    logic                        out_take;

    logic                        r_out_valid, n_out_valid;
    scfp_pkg::t_result           r_out, n_out;
    logic                        r_skid_valid, n_skid_valid;
    scfp_pkg::t_result           r_skid, n_skid;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        case (reg_sel)
            scfp_pkg::REG_START_MARKER: prdata[scfp_pkg::BYTE_W-1:0] = r_start_marker;
            scfp_pkg::REG_END_MARKER:   prdata[scfp_pkg::BYTE_W-1:0] = r_end_marker;
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= scfp_pkg::START_MARKER_RESET;
            r_end_marker   <= scfp_pkg::END_MARKER_RESET;
        end else if (cfg_write) begin
            if (reg_sel == scfp_pkg::REG_START_MARKER) begin
                r_start_marker <= pwdata[scfp_pkg::BYTE_W-1:0];
            end else begin
                r_end_marker <= pwdata[scfp_pkg::BYTE_W-1:0];
            end
        end
    end

    assign o_rx_stall = r_skid_valid;
    assign rx_accept  = i_rx_valid && !r_skid_valid;

    scfp_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (rx_accept),
        .i_byte         (i_rx_byte),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_res_valid    (core_valid),
        .o_res          (core_res)
    );

    assign produce  = rx_accept && core_valid;
    assign out_take = r_out_valid && !i_res_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;

        if (out_take) begin
            n_out_valid = 1'b0;
        end
        if (r_skid_valid && !n_out_valid) begin
            n_out        = r_skid;
            n_out_valid  = 1'b1;
            n_skid_valid = 1'b0;
        end
        // A new result only arrives while the skid register is empty.
        if (produce) begin
            if (!n_out_valid) begin
                n_out       = core_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = core_res;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_res_valid      = r_out_valid;
    assign o_kind           = r_out.kind;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_payload_index  = r_out.payload_index;
    assign o_slave_id       = r_out.slave_id;
    assign o_command_code   = r_out.command_code;
    assign o_payload_length = r_out.payload_length;
    assign o_checksum_good  = r_out.checksum_good;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a transaction while the output is empty");

    a_take_drains_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_res_stall) |=> !r_skid_valid)
        else $error("skid register still full after the output was taken");

    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == scfp_pkg::KIND_STATUS)
            |-> (r_out.payload_byte == '0 && r_out.payload_index == '0))
        else $error("status transaction carries payload data");

    a_payload_no_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == scfp_pkg::KIND_PAYLOAD)
            |-> !r_out.checksum_good)
        else $error("payload transaction flags a good checksum");
`endif

endmodule

`default_nettype wire

// ----- tb/sum_checked_frame_parser_tb.sv -----
`timescale 1ns / 100ps

module sum_checked_frame_parser_tb;

    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned RANDOM_BYTES  = 1200;
    localparam int unsigned CHUNK_BYTES   = 150;
    localparam int unsigned MAX_GAP       = 11;
    localparam int unsigned SEND_ALL      = 1000;
    localparam int unsigned EXP_DEPTH     = 512;
    localparam int unsigned FRAME_MAX     = 262;

    localparam int unsigned SUM_OK    = 0;
    localparam int unsigned SUM_BAD_HI = 1;
    localparam int unsigned SUM_BAD_LO = 2;

    typedef enum logic [2:0] {
        PH_HUNT, PH_SLAVE, PH_CMD, PH_LEN, PH_PAYLOAD, PH_SUM_HI, PH_SUM_LO, PH_TRAIL
    } t_frame_phase;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_rx_valid;
    logic                          o_rx_stall;
    logic [scfp_pkg::BYTE_W-1:0]   i_rx_byte;
    logic                          o_res_valid;
    logic                          i_res_stall;
    logic                          o_kind;
    logic [scfp_pkg::BYTE_W-1:0]   o_payload_byte;
    logic [scfp_pkg::BYTE_W-1:0]   o_payload_index;
    logic [scfp_pkg::BYTE_W-1:0]   o_slave_id;
    logic [scfp_pkg::BYTE_W-1:0]   o_command_code;
    logic [scfp_pkg::BYTE_W-1:0]   o_payload_length;
    logic                          o_checksum_good;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [scfp_pkg::ADDR_W-1:0]   paddr;
    logic [scfp_pkg::DATA_W-1:0]   pwdata;
    logic [scfp_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    sum_checked_frame_parser uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_valid       (i_rx_valid),
        .o_rx_stall       (o_rx_stall),
        .i_rx_byte        (i_rx_byte),
        .o_res_valid      (o_res_valid),
        .i_res_stall      (i_res_stall),
        .o_kind           (o_kind),
        .o_payload_byte   (o_payload_byte),
        .o_payload_index  (o_payload_index),
        .o_slave_id       (o_slave_id),
        .o_command_code   (o_command_code),
        .o_payload_length (o_payload_length),
        .o_checksum_good  (o_checksum_good),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Parser shadow state and marker registers.
    t_frame_phase                m_phase;
    logic [scfp_pkg::BYTE_W-1:0] m_start;
    logic [scfp_pkg::BYTE_W-1:0] m_end;
    logic [scfp_pkg::BYTE_W-1:0] m_slave;
    logic [scfp_pkg::BYTE_W-1:0] m_cmd;
    logic [scfp_pkg::BYTE_W-1:0] m_len;
    logic [scfp_pkg::BYTE_W-1:0] m_count;
    logic [scfp_pkg::SUM_W-1:0]  m_rx_sum;
    logic [scfp_pkg::SUM_W-1:0]  m_sum;

    // Expected results in order, as a ring with free-running read and write counts.
    scfp_pkg::t_result           exp_mem [0:EXP_DEPTH-1];
    int unsigned                 exp_wr;
    int unsigned                 exp_rd;

    logic [scfp_pkg::BYTE_W-1:0] frame_buf [0:FRAME_MAX-1];
    int unsigned                 frame_len;

    int unsigned src_max_gap;
    int unsigned sink_max_pause;
    bit          hold_request;

    int unsigned errors;
    int unsigned bytes_sent;
    int unsigned n_frames;
    int unsigned n_bad_frames;
    int unsigned n_payload_checked;
    int unsigned n_status_checked;
    int unsigned n_marker_writes;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Generous bound: about 2000 bytes, each with the longest gap and stall, plus the hold.
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic void reset_parser_model();
        m_phase  = PH_HUNT;
        m_start  = scfp_pkg::START_MARKER_RESET;
        m_end    = scfp_pkg::END_MARKER_RESET;
        m_slave  = '0;
        m_cmd    = '0;
        m_len    = '0;
        m_count  = '0;
        m_sum    = '0;
        m_rx_sum = '0;
        exp_wr   = 0;
        exp_rd   = 0;
    endfunction

    function automatic void expect_result(input scfp_pkg::t_result r);
        exp_mem[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endfunction

    function automatic scfp_pkg::t_result take_expected();
        scfp_pkg::t_result r;
        r = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        return r;
    endfunction

    function automatic int unsigned pending_results();
        return exp_wr - exp_rd;
    endfunction

    function automatic void add_frame_byte(input logic [scfp_pkg::BYTE_W-1:0] b);
        frame_buf[frame_len] = b;
        frame_len++;
    endfunction

    function automatic scfp_pkg::t_result frame_result(
        input logic kind, input logic [scfp_pkg::BYTE_W-1:0] pbyte,
        input logic [scfp_pkg::BYTE_W-1:0] pidx, input logic good);
        scfp_pkg::t_result r;
        r.kind           = kind;
        r.payload_byte   = pbyte;
        r.payload_index  = pidx;
        r.slave_id       = m_slave;
        r.command_code   = m_cmd;
        r.payload_length = m_len;
        r.checksum_good  = good;
        return r;
    endfunction

    function automatic void parse_byte(input logic [scfp_pkg::BYTE_W-1:0] b);
        logic [scfp_pkg::SUM_W-1:0] total;
        case (m_phase)
            PH_HUNT: begin
                if (b == m_start) begin
                    m_sum    = scfp_pkg::SUM_W'(b);
                    m_count  = '0;
                    m_rx_sum = '0;
                    m_phase  = PH_SLAVE;
                end
            end
            PH_SLAVE: begin
                m_slave = b;
                m_sum   = m_sum + b;
                m_phase = PH_CMD;
            end
            PH_CMD: begin
                m_cmd   = b;
                m_sum   = m_sum + b;
                m_phase = PH_LEN;
            end
            PH_LEN: begin
                m_len   = b;
                m_sum   = m_sum + b;
                m_count = '0;
                m_phase = (b == '0) ? PH_SUM_HI : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                m_sum = m_sum + b;
                expect_result(frame_result(scfp_pkg::KIND_PAYLOAD, b, m_count, 1'b0));
                m_count = m_count + 1'b1;
                if (m_count == m_len) m_phase = PH_SUM_HI;
            end
            PH_SUM_HI: begin
                m_rx_sum = {b, 8'h00};
                m_phase  = PH_SUM_LO;
            end
            PH_SUM_LO: begin
                m_rx_sum = m_rx_sum | scfp_pkg::SUM_W'(b);
                m_phase  = PH_TRAIL;
            end
            default: begin
                // The trailing byte is taken as it is; the end marker counts instead.
                total = m_sum + m_end;
                expect_result(frame_result(scfp_pkg::KIND_STATUS, '0, '0, total == m_rx_sum));
                m_phase = PH_HUNT;
            end
        endcase
    endfunction

    function automatic void field_check(input string field,
                                        input logic [scfp_pkg::BYTE_W-1:0] want,
                                        input logic [scfp_pkg::BYTE_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    function automatic void check_result(input scfp_pkg::t_result got);
        scfp_pkg::t_result want;
        if (pending_results() == 0) begin
            $display("%0t ns: result with nothing expected, expected none, got kind %0d",
                     $time, got.kind);
            errors++;
            return;
        end
        want = take_expected();
        field_check("kind", scfp_pkg::BYTE_W'(want.kind), scfp_pkg::BYTE_W'(got.kind));
        field_check("payload_byte", want.payload_byte, got.payload_byte);
        field_check("payload_index", want.payload_index, got.payload_index);
        field_check("slave_id", want.slave_id, got.slave_id);
        field_check("command_code", want.command_code, got.command_code);
        field_check("payload_length", want.payload_length, got.payload_length);
        field_check("checksum_good", scfp_pkg::BYTE_W'(want.checksum_good),
                    scfp_pkg::BYTE_W'(got.checksum_good));
        if (want.kind == scfp_pkg::KIND_STATUS) n_status_checked++;
        else n_payload_checked++;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_res_valid && !i_res_stall) begin
                check_result({o_kind, o_payload_byte, o_payload_index, o_slave_id,
                              o_command_code, o_payload_length, o_checksum_good});
            end
            if (i_rx_valid && !o_rx_stall) parse_byte(i_rx_byte);
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == scfp_pkg::REG_START_MARKER) m_start = pwdata[7:0];
                    else m_end = pwdata[7:0];
                    n_marker_writes++;
                end else if (prdata !== scfp_pkg::DATA_W'(
                                 (paddr[2] == scfp_pkg::REG_START_MARKER) ? m_start : m_end))
                begin
                    $display("%0t ns: register read mismatch at %0d, expected %0d, got %0d",
                             $time, paddr,
                             (paddr[2] == scfp_pkg::REG_START_MARKER) ? m_start : m_end,
                             prdata);
                    errors++;
                end
            end
        end
    end

    // Result side: a random pause before each result, or one long hold on request.
    initial begin : result_sink
        int unsigned pause;
        i_res_stall = 1'b0;
        forever begin
            pause = hold_request ? LONG_HOLD : $urandom_range(0, sink_max_pause);
            hold_request = 1'b0;
            repeat (pause) begin
                @(negedge i_clk);
                i_res_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_res_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_res_valid && !i_res_stall));
        end
    end

    task automatic send_byte(input logic [scfp_pkg::BYTE_W-1:0] b);
        int unsigned gap;
        gap = $urandom_range(0, src_max_gap);
        repeat (gap) begin
            @(negedge i_clk);
            i_rx_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall);
        bytes_sent++;
    endtask

    // Lets the block run dry: every expected result in, then a settling wait for the last byte.
    task automatic finish_phase();
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (pending_results() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic write, input logic reg_idx,
                              input logic [scfp_pkg::BYTE_W-1:0] value);
        logic [scfp_pkg::DATA_W-1:0] data;
        data = $urandom;
        data[scfp_pkg::BYTE_W-1:0] = value;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= scfp_pkg::ADDR_W'({reg_idx, 2'b00});
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_markers(input logic [scfp_pkg::BYTE_W-1:0] start_val,
                               input logic [scfp_pkg::BYTE_W-1:0] end_val);
        apb_access(1'b1, scfp_pkg::REG_START_MARKER, start_val);
        apb_access(1'b1, scfp_pkg::REG_END_MARKER, end_val);
        apb_access(1'b0, scfp_pkg::REG_START_MARKER, '0);
        apb_access(1'b0, scfp_pkg::REG_END_MARKER, '0);
    endtask

    // Builds a frame for the current markers and sends the first keep bytes of it.
    task automatic send_frame(input logic [scfp_pkg::BYTE_W-1:0] slave,
                              input logic [scfp_pkg::BYTE_W-1:0] cmd,
                              input logic [scfp_pkg::BYTE_W-1:0] len,
                              input int unsigned sum_fault,
                              input int unsigned keep);
        logic [scfp_pkg::SUM_W-1:0]  sum;
        logic [scfp_pkg::BYTE_W-1:0] b;
        logic [scfp_pkg::BYTE_W-1:0] flip;
        frame_len = 0;
        sum = m_start + slave + cmd + len + m_end;
        add_frame_byte(m_start);
        add_frame_byte(slave);
        add_frame_byte(cmd);
        add_frame_byte(len);
        for (int i = 0; i < len; i++) begin
            b = scfp_pkg::BYTE_W'($urandom);
            add_frame_byte(b);
            sum = sum + b;
        end
        flip = scfp_pkg::BYTE_W'($urandom_range(1, 255));
        if (sum_fault == SUM_BAD_HI) sum[15:8] = sum[15:8] ^ flip;
        if (sum_fault == SUM_BAD_LO) sum[7:0] = sum[7:0] ^ flip;
        add_frame_byte(sum[15:8]);
        add_frame_byte(sum[7:0]);
        add_frame_byte(scfp_pkg::BYTE_W'($urandom));
        for (int i = 0; i < frame_len && i < keep; i++) send_byte(frame_buf[i]);
        if (keep >= frame_len) begin
            n_frames++;
            if (sum_fault != SUM_OK) n_bad_frames++;
        end
    endtask

    task automatic send_noise(input int unsigned count);
        logic [scfp_pkg::BYTE_W-1:0] b;
        repeat (count) begin
            do b = scfp_pkg::BYTE_W'($urandom); while (b == m_start);
            send_byte(b);
        end
    endtask

    function automatic logic [scfp_pkg::BYTE_W-1:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return scfp_pkg::BYTE_W'($urandom_range(0, 8));
        if (r < 97) return scfp_pkg::BYTE_W'($urandom_range(9, 40));
        return scfp_pkg::BYTE_W'($urandom_range(200, 255));
    endfunction

    task automatic test_reset_values();
        apb_access(1'b0, scfp_pkg::REG_START_MARKER, '0);
        apb_access(1'b0, scfp_pkg::REG_END_MARKER, '0);
    endtask

    task automatic test_directed_frames();
        logic [scfp_pkg::SUM_W-1:0] sum;
        src_max_gap    = 0;
        sink_max_pause = 0;
        // Outside a frame these are simply dropped.
        send_byte(8'h00);
        send_byte(8'hFF);
        // With zero length the checksum follows the length byte directly.
        send_frame(8'hFF, 8'h00, 8'd0, SUM_OK, SEND_ALL);
        // A start marker inside the payload is plain data; the low checksum byte is off by one.
        sum = m_start + 8'h00 + 8'hFF + 8'd2 + 8'hFF + m_start + m_end;
        send_byte(m_start);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'd2);
        send_byte(8'hFF);
        send_byte(m_start);
        send_byte(sum[15:8]);
        send_byte(sum[7:0] ^ 8'h01);
        send_byte(8'h00);
        n_frames++;
        n_bad_frames++;
        send_frame(8'h5A, 8'hA5, 8'd1, SUM_OK, SEND_ALL);
        finish_phase();
    endtask

    // Markers change while a frame is half received: the sum keeps the old start byte,
    // but the trailing byte adds the new end marker.
    task automatic test_midframe_marker_change();
        logic [scfp_pkg::BYTE_W-1:0] old_start;
        logic [scfp_pkg::SUM_W-1:0]  sum;
        src_max_gap    = 3;
        sink_max_pause = 3;
        old_start = m_start;
        send_byte(m_start);
        send_byte(8'h21);
        send_byte(8'h42);
        send_byte(8'd1);
        send_byte(8'h77);
        finish_phase();
        set_markers(8'hC3, 8'h80);
        sum = old_start + 8'h21 + 8'h42 + 8'd1 + 8'h77 + m_end;
        send_byte(sum[15:8]);
        send_byte(sum[7:0]);
        send_byte(8'h5C);
        n_frames++;
        send_frame(8'h10, 8'h20, 8'd3, SUM_OK, SEND_ALL);
        finish_phase();
    endtask

    task automatic test_marker_extremes();
        src_max_gap    = MAX_GAP;
        sink_max_pause = MAX_GAP;
        set_markers(8'h00, 8'hFF);
        send_noise(3);
        send_frame(8'h01, 8'h02, 8'd4, SUM_OK, SEND_ALL);
        send_frame(8'h03, 8'h04, 8'd2, SUM_BAD_HI, SEND_ALL);
        finish_phase();
        set_markers(8'hFF, 8'h00);
        send_noise(3);
        send_frame(8'h05, 8'h06, 8'd3, SUM_OK, SEND_ALL);
        send_frame(8'h07, 8'h08, 8'd0, SUM_BAD_LO, SEND_ALL);
        finish_phase();
        set_markers(scfp_pkg::START_MARKER_RESET, scfp_pkg::END_MARKER_RESET);
    endtask

    // The receiver holds off for a long stretch while a full-length frame streams in,
    // so the output and skid registers fill and the input stalls.
    task automatic test_backpressure();
        src_max_gap    = 0;
        sink_max_pause = 0;
        hold_request   = 1'b1;
        send_frame(8'hEE, 8'h11, 8'd255, SUM_OK, SEND_ALL);
        finish_phase();
    endtask

    task automatic test_random_traffic();
        int unsigned first_byte;
        int unsigned chunk_end;
        int unsigned pick;
        int unsigned fault;
        logic [scfp_pkg::BYTE_W-1:0] len;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < RANDOM_BYTES) begin
            case ($urandom_range(0, 3))
                0: begin src_max_gap = 0; sink_max_pause = 0; end
                1: begin src_max_gap = MAX_GAP; sink_max_pause = MAX_GAP; end
                2: begin src_max_gap = 0; sink_max_pause = MAX_GAP; end
                default: begin
                    src_max_gap    = $urandom_range(0, MAX_GAP);
                    sink_max_pause = $urandom_range(0, MAX_GAP);
                end
            endcase
            pick = $urandom_range(0, 9);
            if (pick < 2) set_markers($urandom_range(0, 1) ? 8'hFF : 8'h00,
                                      $urandom_range(0, 1) ? 8'hFF : 8'h00);
            else if (pick < 6) set_markers(scfp_pkg::BYTE_W'($urandom),
                                           scfp_pkg::BYTE_W'($urandom));
            chunk_end = bytes_sent + CHUNK_BYTES;
            while (bytes_sent < chunk_end) begin
                pick = $urandom_range(0, 99);
                len  = pick_length();
                if (pick < 10) begin
                    send_noise($urandom_range(1, 3));
                end else if (pick < 18) begin
                    // Broken frame: cut off somewhere, so the next bytes land mid-frame.
                    send_frame(scfp_pkg::BYTE_W'($urandom), scfp_pkg::BYTE_W'($urandom),
                               len, SUM_OK, $urandom_range(1, len + 6));
                end else begin
                    fault = $urandom_range(0, 3);
                    if (fault > SUM_BAD_LO) fault = SUM_OK;
                    send_frame(scfp_pkg::BYTE_W'($urandom), scfp_pkg::BYTE_W'($urandom),
                               len, fault, SEND_ALL);
                end
            end
            finish_phase();
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_rx_valid     = 1'b0;
        i_rx_byte      = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        src_max_gap    = 0;
        sink_max_pause = 0;
        hold_request   = 1'b0;
        reset_parser_model();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_directed_frames();
        test_midframe_marker_change();
        test_marker_extremes();
        test_backpressure();
        test_random_traffic();

        $display("Sent %0d bytes in %0d complete frames (%0d with a bad checksum), %0d marker writes.",
                 bytes_sent, n_frames, n_bad_frames, n_marker_writes);
        $display("Checked %0d payload and %0d status results under random and long back-pressure.",
                 n_payload_checked, n_status_checked);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
